// ===== sv/bdl_pkg.sv =====
// Shared types, character codes and region codes for the brace depth lexer.
package bdl_pkg;

    localparam int MAX_DEPTH_DEF = 255;
    localparam logic [3:0] INDENT_STEP_RST = 4'd4;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;

    localparam logic [10:0] COLS_MAX = 11'h7FF;

    typedef enum logic [2:0] {
        RG_CODE   = 3'd0,
        RG_STRING = 3'd1,
        RG_CHAR   = 3'd2,
        RG_BLOCK  = 3'd3,
        RG_LINE   = 3'd4
    } region_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_last;
        logic       restart;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  nesting_depth;
        logic [10:0] indent_columns;
        logic [2:0]  region;
    } out_beat_t;

    // Lexer flags carried from one byte to the next
    typedef struct packed {
        region_t region;
        logic    escape_pending;
        logic    slash_pending;
        logic    star_pending;
    } lex_flags_t;

endpackage

// ===== sv/brace_depth_lexer.sv =====
// Top level of the brace depth lexer: input stage, lexer state and result register.
//
// Usage:
//   Source text enters on the input channel one byte per beat (in_valid,
//   in_stall, in_data), with line_last marking the last byte of a line and
//   restart clearing depth and lexer state before that byte. Every input beat
//   yields exactly one result beat on the output channel (out_valid,
//   out_stall, out_data): brace depth after the byte, indentation in columns
//   (depth times indent_step, capped at 2047) and the lexical region. The user
//   must write indent_step (cfg_we/cfg_wdata) only while idle; not enforced.
// Timing:
//   A beat lands in the input register, then the lexer update loads the result
//   register. Throughput is one byte per cycle while the output is not stalled;
//   the lexer update plus the small depth-by-step multiply is the only logic
//   between the two registers.
// Reset:
//   rst_n clears both valid bits, the lexer state (depth zero, region code)
//   and sets indent_step to 4.
// Backpressure:
//   While a result is held stalled at the output, the whole pipe freezes and
//   in_stall is raised in the same cycle; no beat is lost or repeated.
module brace_depth_lexer #(
    parameter int MaxDepth = bdl_pkg::MAX_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bdl_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output bdl_pkg::out_beat_t out_data,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata
);

    localparam int DepthW = $clog2(MaxDepth + 1);
    localparam int ExtW   = (DepthW > 8) ? DepthW : 8;

    // Pipe control
    logic               advance;
    logic               s1_valid_reg;
    bdl_pkg::in_beat_t  s1_beat_reg;
    logic               out_valid_reg;
    bdl_pkg::out_beat_t out_data_reg;

    // Lexer state and configuration
    bdl_pkg::lex_flags_t flags_reg;
    bdl_pkg::lex_flags_t flags_next;
    logic [DepthW-1:0]   depth_reg;
    logic [DepthW-1:0]   depth_next;
    bdl_pkg::region_t    region_shown;
    logic [3:0]          step_reg;

    // Result formatting
    logic [ExtW-1:0]     depth_ext;
    logic [7:0]          depth_shown;
    logic [11:0]         cols_full;
    bdl_pkg::out_beat_t  result;

    // Freeze everything only while a finished result is refused downstream
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    bdl_lex_next #(
        .MaxDepth (MaxDepth),
        .DepthW   (DepthW)
    ) u_lex (
        .flags        (flags_reg),
        .depth        (depth_reg),
        .beat         (s1_beat_reg),
        .flags_next   (flags_next),
        .depth_next   (depth_next),
        .region_shown (region_shown)
    );

    // Report depth capped at 255, then scale by the step and cap at 2047
    always_comb
    begin
        depth_ext   = ExtW'(depth_next);
        depth_shown = (depth_ext > ExtW'(255)) ? 8'hFF : depth_ext[7:0];
        cols_full   = {4'b0, depth_shown} * {8'b0, step_reg};
        result.nesting_depth  = depth_shown;
        result.indent_columns = (cols_full > {1'b0, bdl_pkg::COLS_MAX}) ?
                                bdl_pkg::COLS_MAX : cols_full[10:0];
        result.region         = region_shown;
    end

    // Control and state: valid bits, lexer state, indent step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            depth_reg     <= '0;
            step_reg      <= bdl_pkg::INDENT_STEP_RST;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg  <= in_valid;
                out_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                begin
                    flags_reg <= flags_next;
                    depth_reg <= depth_next;
                end
            end
            if (cfg_we)
                step_reg <= cfg_wdata;
        end
    end

    // Payload registers: hold while the pipe is frozen
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_beat_reg <= in_data;
            if (s1_valid_reg)
                out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/bdl_lex_next.sv =====
// Next-state logic of the lexer for one byte: region, pending marks and depth.
module bdl_lex_next #(
    parameter int MaxDepth = bdl_pkg::MAX_DEPTH_DEF,
    parameter int DepthW   = $clog2(MaxDepth + 1)
) (
    input  bdl_pkg::lex_flags_t flags,
    input  logic [DepthW-1:0]   depth,
    input  bdl_pkg::in_beat_t   beat,
    output bdl_pkg::lex_flags_t flags_next,
    output logic [DepthW-1:0]   depth_next,
    output bdl_pkg::region_t    region_shown
);

    localparam logic [DepthW-1:0] DEPTH_TOP = DepthW'(MaxDepth);

    bdl_pkg::lex_flags_t f;
    bdl_pkg::lex_flags_t nf;
    logic [DepthW-1:0]   d;
    logic [DepthW-1:0]   nd;
    logic [7:0]          b;
    logic [7:0]          quote;
    logic                consumed;

    always_comb
    begin
        b        = beat.text_byte;
        f        = beat.restart ? '0 : flags;
        d        = beat.restart ? '0 : depth;
        nf       = f;
        nd       = d;
        consumed = 1'b0;
        quote    = (f.region == bdl_pkg::RG_STRING) ? bdl_pkg::CH_DQUOTE : bdl_pkg::CH_SQUOTE;

        case (f.region)
            bdl_pkg::RG_BLOCK:
            begin
                if (f.star_pending && b == bdl_pkg::CH_SLASH)
                begin
                    nf.region       = bdl_pkg::RG_CODE;
                    nf.star_pending = 1'b0;
                end
                else
                begin
                    nf.star_pending = (b == bdl_pkg::CH_STAR) && !beat.line_last;
                end
            end
            bdl_pkg::RG_LINE:
            begin
                nf = f;
            end
            bdl_pkg::RG_STRING, bdl_pkg::RG_CHAR:
            begin
                if (f.escape_pending)
                    nf.escape_pending = 1'b0;
                else if (b == quote)
                    nf.region = bdl_pkg::RG_CODE;
                else if (b == bdl_pkg::CH_BACKSLASH)
                    nf.escape_pending = 1'b1;
            end
            default:
            begin
                nf.region = bdl_pkg::RG_CODE;
                // Second byte of a comment opener
                if (f.slash_pending)
                begin
                    nf.slash_pending = 1'b0;
                    if (b == bdl_pkg::CH_SLASH)
                    begin
                        nf.region = bdl_pkg::RG_LINE;
                        consumed  = 1'b1;
                    end
                    else if (b == bdl_pkg::CH_STAR)
                    begin
                        nf.region       = bdl_pkg::RG_BLOCK;
                        nf.star_pending = 1'b0;
                        consumed        = 1'b1;
                    end
                end
                if (!consumed)
                begin
                    if (b == bdl_pkg::CH_DQUOTE)
                    begin
                        nf.region         = bdl_pkg::RG_STRING;
                        nf.escape_pending = 1'b0;
                    end
                    else if (b == bdl_pkg::CH_SQUOTE)
                    begin
                        nf.region         = bdl_pkg::RG_CHAR;
                        nf.escape_pending = 1'b0;
                    end
                    else if (b == bdl_pkg::CH_SLASH)
                    begin
                        nf.slash_pending = !beat.line_last;
                    end
                    else if (b == bdl_pkg::CH_LBRACE)
                    begin
                        if (d < DEPTH_TOP)
                            nd = d + DepthW'(1);
                    end
                    else if (b == bdl_pkg::CH_RBRACE)
                    begin
                        if (d != '0)
                            nd = d - DepthW'(1);
                    end
                end
            end
        endcase

        region_shown = nf.region;

        // Drop line-scoped state at the end of a line; block comments persist
        if (beat.line_last)
        begin
            nf.escape_pending = 1'b0;
            nf.slash_pending  = 1'b0;
            nf.star_pending   = 1'b0;
            if (nf.region != bdl_pkg::RG_BLOCK)
                nf.region = bdl_pkg::RG_CODE;
        end

        flags_next = nf;
        depth_next = nd;
    end

endmodule

// ===== sv/bdl_check.sv =====
// Port-level checker for the brace depth lexer and its bind to the top level.
module bdl_check (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input bdl_pkg::out_beat_t out_data
);

    // Input is held back only while a result is refused downstream
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall raised without a stalled output beat");

    // Zero depth always means zero indentation
    a_zero_cols: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.nesting_depth == 8'd0) |-> (out_data.indent_columns == 11'd0))
        else $error("indent_columns nonzero at depth zero");

    // A stalled result beat stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output beat dropped while stalled");

    // A stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_data))
        else $error("output payload changed while stalled");

endmodule

bind brace_depth_lexer bdl_check u_bdl_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
